FILE: rtl/upq_pkg.sv
// ---------------------------------------------------------------------------
// upq_pkg
// Shared constants, codes and types of the updatable priority task queue.
// ---------------------------------------------------------------------------
package upq_pkg;

    localparam int ENTRIES     = 64;
    localparam int ID_BITS     = 16;
    localparam int PRIO_BITS   = 32;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;

    // Request modes
    localparam logic [MODE_BITS-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_EDIT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REM  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_EXEC = 2'd3;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_DUPLICATE = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOOKUP,
        CELL_POP,
        CELL_SHIFT_UP,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        logic                 valid;
        logic [ID_BITS-1:0]   task_id;
        logic [ID_BITS-1:0]   user_id;
        logic [PRIO_BITS-1:0] prio;
    } cell_data_t;

    typedef struct packed {
        cell_op_t             op;
        logic [ID_BITS-1:0]   task_id;
        logic [ID_BITS-1:0]   user_id;
        logic [PRIO_BITS-1:0] prio;
    } cell_cmd_t;

endpackage

FILE: rtl/upq_req_if.sv
// ---------------------------------------------------------------------------
// upq_req_if
// Request channel: valid/ready handshake with the task queue request payload.
// ---------------------------------------------------------------------------
interface upq_req_if;

    logic                            valid;
    logic                            ready;
    logic [upq_pkg::MODE_BITS-1:0]   mode;
    logic [upq_pkg::ID_BITS-1:0]     user_id;
    logic [upq_pkg::ID_BITS-1:0]     task_id;
    logic [upq_pkg::PRIO_BITS-1:0]   priority_req;

    modport source (output valid, output mode, output user_id, output task_id,
                    output priority_req, input ready);
    modport sink   (input valid, input mode, input user_id, input task_id,
                    input priority_req, output ready);

endinterface

FILE: rtl/upq_rsp_if.sv
// ---------------------------------------------------------------------------
// upq_rsp_if
// Response channel: valid/ready handshake with status and executed user id.
// ---------------------------------------------------------------------------
interface upq_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [upq_pkg::STATUS_BITS-1:0]   status;
    logic [upq_pkg::ID_BITS-1:0]       user_id_out;

    modport source (output valid, output status, output user_id_out, input ready);
    modport sink   (input valid, input status, input user_id_out, output ready);

endinterface

FILE: rtl/upq_cell.sv
// ---------------------------------------------------------------------------
// upq_cell
// One slot of the sorted task chain: holds a task, compares it against the
// broadcast key and moves data to or from its neighbors.
// ---------------------------------------------------------------------------
module upq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  upq_pkg::cell_cmd_t  cmd,
    input  upq_pkg::cell_data_t left,
    input  logic                left_gt,
    input  upq_pkg::cell_data_t right,
    output upq_pkg::cell_data_t data,
    output logic                gt,
    output logic                match
);

    logic                           valid_reg;
    logic [upq_pkg::ID_BITS-1:0]    task_id_reg;
    logic [upq_pkg::ID_BITS-1:0]    user_id_reg;
    logic [upq_pkg::PRIO_BITS-1:0]  prio_reg;
    upq_pkg::cell_data_t            held;
    upq_pkg::cell_data_t            data_next;
    logic                match_reg;
    logic                match_next;
    logic [upq_pkg::PRIO_BITS+upq_pkg::ID_BITS-1:0] own_key;
    logic [upq_pkg::PRIO_BITS+upq_pkg::ID_BITS-1:0] cmd_key;
    logic                own_above;

    assign held      = {valid_reg, task_id_reg, user_id_reg, prio_reg};
    assign own_key   = {held.prio, held.task_id};
    assign cmd_key   = {cmd.prio, cmd.task_id};
    assign own_above = held.valid && (own_key > cmd_key);
    // New key belongs at or before this slot (empty slots rank lowest)
    assign gt        = !held.valid || (cmd_key > own_key);

    always_comb
    begin
        data_next  = held;
        match_next = match_reg;
        unique case (cmd.op)
            upq_pkg::CELL_HOLD:
            begin
                data_next = held;
            end
            upq_pkg::CELL_LOOKUP:
            begin
                match_next = held.valid && (held.task_id == cmd.task_id);
            end
            upq_pkg::CELL_POP:
            begin
                data_next = right;
            end
            upq_pkg::CELL_SHIFT_UP:
            begin
                // close the gap left by the removed key
                if (!own_above)
                begin
                    data_next = right;
                end
            end
            upq_pkg::CELL_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        data_next = left;
                    end
                    else
                    begin
                        data_next.valid   = 1'b1;
                        data_next.task_id = cmd.task_id;
                        data_next.user_id = cmd.user_id;
                        data_next.prio    = cmd.prio;
                    end
                end
            end
            default:
            begin
                data_next = held;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_next.valid;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_id_reg <= data_next.task_id;
        user_id_reg <= data_next.user_id;
        prio_reg    <= data_next.prio;
    end

    assign data  = held;
    assign match = match_reg;

endmodule

FILE: rtl/updatable_priority_task_queue.sv
// ---------------------------------------------------------------------------
// updatable_priority_task_queue
// Indexed max-priority task queue with priority update, built as a chain of
// cells kept sorted by descending (priority, task id).
// ---------------------------------------------------------------------------
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+------------------------------------------
//   req     | in  | valid/ready | mode, user_id, task_id, priority_req
//   rsp     | out | valid/ready | status, user_id_out
//
// Steps: add, remove and execute-top accept with a task lookup in every cell,
// then make one chain move; an edit that finds its task removes it, then
// re-inserts it. A new request is accepted only after the last one's chain moves.
// Reset: all slots read as empty right after reset; no clearing pass.
// Stalls: a result waits in the output register; the next request is
// accepted meanwhile, and its chain move holds until that result is taken.
// ---------------------------------------------------------------------------
module updatable_priority_task_queue (
    input  logic     clk,
    input  logic     rst_n,
    upq_req_if.sink  req,
    upq_rsp_if.source rsp
);

    localparam int N = upq_pkg::ENTRIES;

    // Request hold registers
    upq_pkg::state_t                  state_reg;
    upq_pkg::state_t                  state_next;
    logic [upq_pkg::MODE_BITS-1:0]    mode_reg;
    logic [upq_pkg::ID_BITS-1:0]      task_reg;
    logic [upq_pkg::ID_BITS-1:0]      user_reg;
    logic [upq_pkg::ID_BITS-1:0]      user_next;
    logic [upq_pkg::PRIO_BITS-1:0]    prio_reg;

    // Output register
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    logic [upq_pkg::STATUS_BITS-1:0]  rsp_status_reg;
    logic [upq_pkg::STATUS_BITS-1:0]  rsp_status_next;
    logic [upq_pkg::ID_BITS-1:0]      rsp_user_reg;
    logic [upq_pkg::ID_BITS-1:0]      rsp_user_next;

    // Chain
    upq_pkg::cell_cmd_t               cmd;
    upq_pkg::cell_data_t              cell_data [N];
    logic [N-1:0]                     cell_gt;
    logic [N-1:0]                     cell_match;

    logic                             accept;
    logic                             out_free;
    logic                             any_match;
    logic [upq_pkg::PRIO_BITS-1:0]    match_prio;
    logic [upq_pkg::ID_BITS-1:0]      match_user;
    logic                             table_full;
    logic                             table_empty;

    assign req.ready   = (state_reg == upq_pkg::S_IDLE);
    assign accept      = req.valid && req.ready;
    // result register can take a new result this cycle
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign table_full  = cell_data[N-1].valid;
    assign table_empty = !cell_data[0].valid;

    // Gather the matching slot; task ids are unique so at most one matches
    always_comb
    begin
        any_match  = 1'b0;
        match_prio = '0;
        match_user = '0;
        for (int i = 0; i < N; i++)
        begin
            any_match  = any_match | cell_match[i];
            match_prio = match_prio | ({upq_pkg::PRIO_BITS{cell_match[i]}} & cell_data[i].prio);
            match_user = match_user | ({upq_pkg::ID_BITS{cell_match[i]}} & cell_data[i].user_id);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            upq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = upq_pkg::S_EXEC;
                end
            end
            upq_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    if (mode_reg == upq_pkg::MODE_EDIT && any_match)
                    begin
                        state_next = upq_pkg::S_INSERT;
                    end
                    else
                    begin
                        state_next = upq_pkg::S_IDLE;
                    end
                end
            end
            upq_pkg::S_INSERT:
            begin
                if (out_free)
                begin
                    state_next = upq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = upq_pkg::S_IDLE;
            end
        endcase
    end

    // Chain command and result
    always_comb
    begin
        cmd.op          = upq_pkg::CELL_HOLD;
        cmd.task_id     = task_reg;
        cmd.user_id     = user_reg;
        cmd.prio        = prio_reg;
        user_next       = user_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_user_next   = rsp_user_reg;

        unique case (state_reg)
            upq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // every cell checks its task id against the new request
                    cmd.op      = upq_pkg::CELL_LOOKUP;
                    cmd.task_id = req.task_id;
                    user_next   = req.user_id;
                end
            end
            upq_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = upq_pkg::STATUS_OK;
                    rsp_user_next   = '0;
                    unique case (mode_reg)
                        upq_pkg::MODE_ADD:
                        begin
                            if (any_match)
                            begin
                                rsp_status_next = upq_pkg::STATUS_DUPLICATE;
                            end
                            else if (table_full)
                            begin
                                rsp_status_next = upq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cmd.op = upq_pkg::CELL_INSERT;
                            end
                        end
                        upq_pkg::MODE_EDIT:
                        begin
                            if (!any_match)
                            begin
                                rsp_status_next = upq_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                // drop the old entry now, re-insert next cycle
                                cmd.op         = upq_pkg::CELL_SHIFT_UP;
                                cmd.prio       = match_prio;
                                user_next      = match_user;
                                rsp_valid_next = rsp_valid_reg && !rsp.ready;
                                rsp_status_next = rsp_status_reg;
                                rsp_user_next  = rsp_user_reg;
                            end
                        end
                        upq_pkg::MODE_REM:
                        begin
                            if (!any_match)
                            begin
                                rsp_status_next = upq_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.op   = upq_pkg::CELL_SHIFT_UP;
                                cmd.prio = match_prio;
                            end
                        end
                        upq_pkg::MODE_EXEC:
                        begin
                            if (table_empty)
                            begin
                                rsp_status_next = upq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // head of the chain is the top task
                                cmd.op        = upq_pkg::CELL_POP;
                                rsp_user_next = cell_data[0].user_id;
                            end
                        end
                        default:
                        begin
                            rsp_status_next = upq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            upq_pkg::S_INSERT:
            begin
                if (out_free)
                begin
                    cmd.op          = upq_pkg::CELL_INSERT;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = upq_pkg::STATUS_OK;
                    rsp_user_next   = '0;
                end
            end
            default:
            begin
                cmd.op = upq_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            task_reg <= req.task_id;
            prio_reg <= req.priority_req;
        end
        user_reg       <= user_next;
        rsp_status_reg <= rsp_status_next;
        rsp_user_reg   <= rsp_user_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.user_id_out = rsp_user_reg;

    // Sorted chain, head at index 0
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        upq_pkg::cell_data_t left_data;
        upq_pkg::cell_data_t right_data;
        logic                left_gt;

        if (g == 0)
        begin : g_head
            assign left_data = '0;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_body
            assign left_data = cell_data[g-1];
            assign left_gt   = cell_gt[g-1];
        end

        if (g == N - 1)
        begin : g_tail
            assign right_data = '0;
        end
        else
        begin : g_next
            assign right_data = cell_data[g+1];
        end

        upq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .left    (left_data),
            .left_gt (left_gt),
            .right   (right_data),
            .data    (cell_data[g]),
            .gt      (cell_gt[g]),
            .match   (cell_match[g])
        );
    end

endmodule

FILE: rtl/upq_checker.sv
// ---------------------------------------------------------------------------
// upq_checker
// Port-level checks of the task queue, attached to the top level by bind.
// ---------------------------------------------------------------------------
module upq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [upq_pkg::STATUS_BITS-1:0]   rsp_status,
    input logic [upq_pkg::ID_BITS-1:0]       rsp_user_id_out
);

    // A held result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // One request in work at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in work");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == upq_pkg::STATUS_OK ||
                       rsp_status == upq_pkg::STATUS_EMPTY ||
                       rsp_status == upq_pkg::STATUS_FULL ||
                       rsp_status == upq_pkg::STATUS_NOT_FOUND ||
                       rsp_status == upq_pkg::STATUS_DUPLICATE))
        else $error("undefined status code");

    // A failed request carries no user id
    a_user_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != upq_pkg::STATUS_OK |-> rsp_user_id_out == '0)
        else $error("user id on failed request");

endmodule

bind updatable_priority_task_queue upq_checker u_upq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_user_id_out (rsp.user_id_out)
);

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the updatable priority task queue against a cycle-free predictor of
// its slot table: a directed table first, then random request blends that
// grow, fill, stall and drain the queue while both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import upq_pkg::*;

    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_N  = 21;

    // One request as the sender offers it.
    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [ID_BITS-1:0]   user_id;
        logic [ID_BITS-1:0]   task_id;
        logic [PRIO_BITS-1:0] prio;
    } request_t;

    // One result as the queue returns it.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     user_id;
    } result_t;

    // Directed row: a request and, where it is obvious, its typed-in result.
    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [ID_BITS-1:0]     user_id;
        logic [ID_BITS-1:0]     task_id;
        logic [PRIO_BITS-1:0]   prio;
        logic                   typed;
        logic [STATUS_BITS-1:0] exp_status;
        logic [ID_BITS-1:0]     exp_user;
    } directed_row_t;

    typedef enum int {
        MIX_OPS,
        GROW_OPS,
        SHRINK_OPS
    } blend_t;

    logic clk;
    logic rst_n;

    upq_req_if req_ch ();
    upq_rsp_if rsp_ch ();

    updatable_priority_task_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the slot table, advanced once per accepted request.
    logic                 slot_used [ENTRIES];
    logic [ID_BITS-1:0]   slot_task [ENTRIES];
    logic [ID_BITS-1:0]   slot_user [ENTRIES];
    logic [PRIO_BITS-1:0] slot_prio [ENTRIES];

    // Results still owed by the queue, oldest first.
    result_t pending_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    bit  hold_off_start = 1'b0;
    bit  req_idle_on    = 1'b1;
    bit  rsp_idle_on    = 1'b1;

    // Directed requests: empty-table errors, extreme ids and priorities,
    // tie-break on task id, unsigned priority order and edit of a live task.
    directed_row_t directed_rows [DIRECTED_N] = '{
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY,     16'h0000},
        '{MODE_EDIT, 16'h0000, 16'h1234, 32'h0000_0005, 1'b1, STATUS_NOT_FOUND, 16'h0000},
        '{MODE_REM,  16'h0000, 16'hFFFF, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 16'h0000},
        '{MODE_ADD,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK,        16'h0000},
        '{MODE_ADD,  16'h0001, 16'hFFFF, 32'h0000_0000, 1'b1, STATUS_DUPLICATE, 16'h0000},
        '{MODE_ADD,  16'h0000, 16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,        16'h0000},
        '{MODE_ADD,  16'h1234, 16'h0005, 32'hFFFF_FFFF, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,        16'hFFFF},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EDIT, 16'h0000, 16'h0000, 32'h8000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_ADD,  16'hAAAA, 16'h0007, 32'h7FFF_FFFF, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_REM,  16'h0000, 16'h0007, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY,     16'h0000},
        '{MODE_ADD,  16'h5555, 16'h8000, 32'h0000_0001, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_ADD,  16'h2AAA, 16'h7FFF, 32'h0000_0001, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EDIT, 16'h0000, 16'h8000, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_REM,  16'h0000, 16'h7FFF, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,        16'h0000},
        '{MODE_EXEC, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY,     16'h0000}
    };

    // -----------------------------------------------------------------------
    // Predictor of the slot table
    // -----------------------------------------------------------------------

    // Return the slot that holds a live task with this id, or -1.
    function automatic int slot_of_task(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_task[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
                n++;
        return n;
    endfunction

    // Apply one request to the shadow table and return the result it earns.
    function automatic result_t queue_apply(input request_t r);
        result_t res;
        int      slot;
        res.status  = STATUS_OK;
        res.user_id = '0;
        slot        = -1;
        case (r.mode)
            MODE_ADD:
            begin
                // Duplicate check wins over the full check.
                if (slot_of_task(r.task_id) >= 0)
                    res.status = STATUS_DUPLICATE;
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!slot_used[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        res.status = STATUS_FULL;
                    else
                    begin
                        slot_used[slot] = 1'b1;
                        slot_task[slot] = r.task_id;
                        slot_user[slot] = r.user_id;
                        slot_prio[slot] = r.prio;
                    end
                end
            end
            MODE_EDIT:
            begin
                slot = slot_of_task(r.task_id);
                if (slot < 0)
                    res.status = STATUS_NOT_FOUND;
                else
                    slot_prio[slot] = r.prio;
            end
            MODE_REM:
            begin
                slot = slot_of_task(r.task_id);
                if (slot < 0)
                    res.status = STATUS_NOT_FOUND;
                else
                    slot_used[slot] = 1'b0;
            end
            default:
            begin
                // Highest unsigned priority; on a tie the higher task id.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_used[i] &&
                        (slot < 0 || slot_prio[i] > slot_prio[slot] ||
                         (slot_prio[i] == slot_prio[slot] &&
                          slot_task[i] > slot_task[slot])))
                        slot = i;
                end
                if (slot < 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.user_id     = slot_user[slot];
                    slot_used[slot] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Pick the id of a random live task; fall back to any id when empty.
    function automatic logic [ID_BITS-1:0] live_task_id();
        int n;
        int pick;
        n = live_count();
        if (n == 0)
            return ID_BITS'($urandom_range(16'hFFFF));
        pick = $urandom_range(n - 1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_used[i])
            begin
                if (pick == 0)
                    return slot_task[i];
                pick--;
            end
        end
        return '0;
    endfunction

    // Half the fresh ids come from a narrow pool so collisions happen.
    function automatic logic [ID_BITS-1:0] fresh_task_id();
        if ($urandom_range(1) == 0)
            return ID_BITS'($urandom_range(255));
        return ID_BITS'($urandom_range(16'hFFFF));
    endfunction

    // Narrow values force ties; extremes probe the unsigned compare.
    function automatic logic [PRIO_BITS-1:0] random_prio();
        case ($urandom_range(9))
            0, 1, 2, 3: return PRIO_BITS'($urandom_range(7));
            4:
            begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return PRIO_BITS'($urandom());
        endcase
    endfunction

    // Offer one request, hold it until accepted, then record its result.
    // A typed result replaces the predicted one; the table advances anyway.
    task automatic issue_request(input request_t r, input bit typed,
                                 input result_t typed_res);
        result_t res;
        while (req_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= r.mode;
        req_ch.user_id      <= r.user_id;
        req_ch.task_id      <= r.task_id;
        req_ch.priority_req <= r.prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        res = queue_apply(r);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic issue_predicted(input request_t r);
        issue_request(r, 1'b0, '0);
    endtask

    // Random blend of requests; the blend steers the table occupancy.
    task automatic run_blend(input blend_t blend, input int count);
        request_t r;
        int       roll;
        int       add_pct;
        int       edit_pct;
        int       rem_pct;
        case (blend)
            GROW_OPS:
            begin
                add_pct  = 60;
                edit_pct = 15;
                rem_pct  = 10;
            end
            SHRINK_OPS:
            begin
                add_pct  = 15;
                edit_pct = 10;
                rem_pct  = 20;
            end
            default:
            begin
                add_pct  = 30;
                edit_pct = 20;
                rem_pct  = 20;
            end
        endcase
        for (int k = 0; k < count; k++)
        begin
            roll      = $urandom_range(99);
            r.user_id = ID_BITS'($urandom_range(16'hFFFF));
            r.prio    = random_prio();
            if (roll < add_pct)
            begin
                r.mode    = MODE_ADD;
                r.task_id = ($urandom_range(99) < 15) ? live_task_id() : fresh_task_id();
            end
            else if (roll < add_pct + edit_pct + rem_pct)
            begin
                r.mode    = (roll < add_pct + edit_pct) ? MODE_EDIT : MODE_REM;
                r.task_id = ($urandom_range(99) < 80) ? live_task_id() : fresh_task_id();
            end
            else
            begin
                r.mode    = MODE_EXEC;
                r.task_id = ID_BITS'($urandom_range(16'hFFFF));
            end
            issue_predicted(r);
        end
    endtask

    // Fill every slot, then push past full with new and duplicate ids.
    task automatic fill_table();
        request_t r;
        r.mode = MODE_ADD;
        while (live_count() < ENTRIES)
        begin
            r.user_id = ID_BITS'($urandom_range(16'hFFFF));
            r.task_id = ID_BITS'($urandom_range(16'hFFFF));
            r.prio    = random_prio();
            issue_predicted(r);
        end
        for (int k = 0; k < 6; k++)
        begin
            r.user_id = ID_BITS'($urandom_range(16'hFFFF));
            r.task_id = (k % 2 == 0) ? fresh_task_id() : live_task_id();
            r.prio    = random_prio();
            issue_predicted(r);
        end
    endtask

    // -----------------------------------------------------------------------
    // Clock, reset and run limit
    // -----------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run; the limit is far above the slowest correct run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: ready with random idling and one long hold-off
    // -----------------------------------------------------------------------

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_start)
            begin
                hold_left      = HOLD_CYCLES;
                hold_off_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (rsp_idle_on && $urandom_range(99) < IDLE_PCT)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, got status %0d user %h",
                             $time, rsp_ch.status, rsp_ch.user_id_out);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t ns: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.user_id_out !== want.user_id)
                    begin
                        mismatch_count++;
                        $display("%0t ns: user_id_out mismatch, expected %h, got %h",
                                 $time, want.user_id, rsp_ch.user_id_out);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------

    initial
    begin
        request_t r;
        result_t  typed_res;

        // Drive every request input to a known value and hold reset.
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_ADD;
        req_ch.user_id      <= '0;
        req_ch.task_id      <= '0;
        req_ch.priority_req <= '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_task[i] = '0;
            slot_user[i] = '0;
            slot_prio[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed_rows[i])
        begin
            r.mode            = directed_rows[i].mode;
            r.user_id         = directed_rows[i].user_id;
            r.task_id         = directed_rows[i].task_id;
            r.prio            = directed_rows[i].prio;
            typed_res.status  = directed_rows[i].exp_status;
            typed_res.user_id = directed_rows[i].exp_user;
            issue_request(r, directed_rows[i].typed, typed_res);
        end

        // Random part: mixed traffic, then grow into a full table.
        run_blend(MIX_OPS, 200);
        run_blend(GROW_OPS, 150);
        fill_table();

        // Hold off the result side while the sender keeps offering, so the
        // output register fills and the queue stalls its request input.
        req_idle_on    = 1'b0;
        hold_off_start = 1'b1;
        run_blend(MIX_OPS, 40);
        req_idle_on    = 1'b1;

        run_blend(SHRINK_OPS, 200);

        // Long stretch at full rate on both sides.
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        run_blend(MIX_OPS, 300);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;

        run_blend(GROW_OPS, 200);
        fill_table();
        run_blend(SHRINK_OPS, 250);
        run_blend(MIX_OPS, 300);
        run_blend(SHRINK_OPS, 150);

        // Drop valid and drain the remaining results.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
